/* src/wav_header_check_and_decimate_core_macros.svh */
`ifndef WAV_HEADER_CHECK_AND_DECIMATE_CORE_MACROS_SVH
`define WAV_HEADER_CHECK_AND_DECIMATE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define WAVHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define WAVHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/wavhc_pkg.sv */
package wavhc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [3:0]         error_code;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic        smp_valid;
    logic [15:0] raw;
    logic        tail_valid;
    logic [1:0]  tail_kind;
    logic [3:0]  tail_code;
  } cmd_t;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ERR_RIFF      = 4'd0;
  localparam logic [3:0] ERR_WAVEFMT   = 4'd1;
  localparam logic [3:0] ERR_CHUNK     = 4'd2;
  localparam logic [3:0] ERR_FORMAT    = 4'd3;
  localparam logic [3:0] ERR_CHANNELS  = 4'd4;
  localparam logic [3:0] ERR_RATE      = 4'd5;
  localparam logic [3:0] ERR_BYTE_RATE = 4'd6;
  localparam logic [3:0] ERR_BITS      = 4'd7;
  localparam logic [3:0] ERR_DATA_TAG  = 4'd8;
  localparam logic [3:0] ERR_TRUNC     = 4'd9;
  localparam logic [3:0] CODE_CAPTURE  = 4'd14;
  localparam logic [3:0] CODE_NOCHECK  = 4'd15;

  localparam logic [5:0]  HDR_LAST    = 6'd43;
  localparam logic [14:0] SCALE_RESET = 15'd256;
  localparam int unsigned CMDQ_DEPTH  = 4;
  localparam int unsigned CMDQ_AW     = $clog2(CMDQ_DEPTH);
  localparam logic [3:0]  DIV_LAST    = 4'd15;

  function automatic logic [3:0] hdr_code(input logic [5:0] idx);
    logic [3:0] c;
    case (idx)
      6'd0, 6'd1, 6'd2, 6'd3:                         c = ERR_RIFF;
      6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15: c = ERR_WAVEFMT;
      6'd16, 6'd17, 6'd18, 6'd19:                     c = ERR_CHUNK;
      6'd20, 6'd21:                                   c = ERR_FORMAT;
      6'd22, 6'd23:                                   c = ERR_CHANNELS;
      6'd24, 6'd25, 6'd26, 6'd27:                     c = ERR_RATE;
      6'd28, 6'd29, 6'd30, 6'd31:                     c = ERR_BYTE_RATE;
      6'd34, 6'd35:                                   c = ERR_BITS;
      6'd36, 6'd37, 6'd38, 6'd39:                     c = ERR_DATA_TAG;
      6'd40, 6'd41, 6'd42, 6'd43:                     c = CODE_CAPTURE;
      default:                                        c = CODE_NOCHECK;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hdr_expect(input logic [5:0] idx);
    logic [7:0] e;
    case (idx)
      6'd0:    e = 8'h52;
      6'd1:    e = 8'h49;
      6'd2:    e = 8'h46;
      6'd3:    e = 8'h46;
      6'd8:    e = 8'h57;
      6'd9:    e = 8'h41;
      6'd10:   e = 8'h56;
      6'd11:   e = 8'h45;
      6'd12:   e = 8'h66;
      6'd13:   e = 8'h6d;
      6'd14:   e = 8'h74;
      6'd15:   e = 8'h20;
      6'd16:   e = 8'h10;
      6'd20:   e = 8'h01;
      6'd22:   e = 8'h01;
      6'd24:   e = 8'h44;
      6'd25:   e = 8'hac;
      6'd28:   e = 8'h88;
      6'd29:   e = 8'h58;
      6'd30:   e = 8'h01;
      6'd34:   e = 8'h10;
      6'd36:   e = 8'h64;
      6'd37:   e = 8'h61;
      6'd38:   e = 8'h74;
      6'd39:   e = 8'h61;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

/* src/wav_header_check_and_decimate_core.sv */
// Path: a byte that yields a sample goes through the command queue, the bit-serial divider
// and the output register; a done or error beat goes through the queue and the tail state.
// Throughput: one byte per cycle while the 4-entry command queue has room; each kept sample
// (one per four data bytes) holds the back end in the divider, so the queue can fill and stall input.
// Reset (rst_ni low, asynchronous): parser back to the header, queues empty, scale to 256.
module wav_header_check_and_decimate_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  wavhc_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output wavhc_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [14:0]          cfg_data_i
);
  import wavhc_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wcmd, q_rcmd;

  assign cfg_ready_o = 1'b1;

  wavhc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_wcmd)
  );

  wavhc_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rcmd),
    .empty_o (q_empty)
  );

  wavhc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_rcmd),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

/* src/wavhc_front.sv */
module wavhc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  wavhc_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output wavhc_pkg::cmd_t   q_cmd_o
);
  import wavhc_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR  = 3'b001,
    PH_DATA = 3'b010,
    PH_SKIP = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [5:0]  hdr_idx_q, hdr_idx_d;
  logic [31:0] dcnt_q, dcnt_d;
  logic [31:0] len_q, len_d;
  logic        fld_err_q, fld_err_d;
  logic [7:0]  low_q, low_d;

  logic        accept;
  logic [7:0]  b;
  logic [3:0]  code;
  logic        chk;
  logic        fs;
  logic        fend;
  logic        fin;
  logic [31:0] dnext;
  cmd_t        cmd;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign b      = in_item_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    dcnt_d    = dcnt_q;
    len_d     = len_q;
    fld_err_d = fld_err_q;
    low_d     = low_q;
    fin       = 1'b0;
    cmd       = '0;
    code      = hdr_code(hdr_idx_q);
    chk       = (code <= ERR_DATA_TAG);
    fs        = fld_err_q || (chk && (b != hdr_expect(hdr_idx_q)));
    fend      = (hdr_idx_q == HDR_LAST) || (hdr_code(hdr_idx_q + 6'd1) != code);
    dnext     = dcnt_q + 32'd1;

    case (phase_q)
      PH_HDR: begin
        hdr_idx_d = hdr_idx_q + 6'd1;
        if (code == CODE_CAPTURE) begin
          len_d[{hdr_idx_q[1:0], 3'b000} +: 8] = b;
        end
        if (fend && chk && fs) begin
          cmd.tail_valid = 1'b1;
          cmd.tail_kind  = KIND_ERROR;
          cmd.tail_code  = code;
          phase_d        = PH_SKIP;
          fin            = 1'b1;
        end else if (hdr_idx_q == HDR_LAST) begin
          hdr_idx_d = '0;
          dcnt_d    = '0;
          if (len_d == 32'd0) begin
            cmd.tail_valid = 1'b1;
            cmd.tail_kind  = KIND_DONE;
            phase_d        = PH_SKIP;
            fin            = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
        fld_err_d = fend ? 1'b0 : fs;
      end
      PH_DATA: begin
        if (dcnt_q[1:0] == 2'd0) begin
          low_d = b;
        end else if (dcnt_q[1:0] == 2'd1) begin
          cmd.smp_valid = 1'b1;
          cmd.raw       = {b, low_q};
        end
        dcnt_d = dnext;
        if (dnext == len_q) begin
          cmd.tail_valid = 1'b1;
          cmd.tail_kind  = KIND_DONE;
          phase_d        = PH_SKIP;
          fin            = 1'b1;
        end
      end
      PH_SKIP: begin
      end
      default: begin
        phase_d = PH_HDR;
      end
    endcase

    if (in_item_i.end_of_file) begin
      if (!fin && phase_q != PH_SKIP) begin
        cmd.tail_valid = 1'b1;
        cmd.tail_kind  = KIND_ERROR;
        cmd.tail_code  = ERR_TRUNC;
      end
      phase_d   = PH_HDR;
      hdr_idx_d = '0;
      dcnt_d    = '0;
      len_d     = '0;
      fld_err_d = 1'b0;
      low_d     = '0;
    end
  end

  assign q_push_o = accept && (cmd.smp_valid || cmd.tail_valid);
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      hdr_idx_q <= '0;
      dcnt_q    <= '0;
      len_q     <= '0;
      fld_err_q <= 1'b0;
      low_q     <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      dcnt_q    <= dcnt_d;
      len_q     <= len_d;
      fld_err_q <= fld_err_d;
      low_q     <= low_d;
    end
  end

endmodule

/* src/wavhc_cmdq.sv */
module wavhc_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wavhc_pkg::cmd_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output wavhc_pkg::cmd_t rdata_o,
  output logic            empty_o
);
  import wavhc_pkg::*;

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_q, rd_q;
  logic [CMDQ_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/wavhc_back.sv */
`include "wav_header_check_and_decimate_core_macros.svh"

module wavhc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [14:0]          cfg_data_i,
  input  logic                 q_empty_i,
  input  wavhc_pkg::cmd_t      q_cmd_i,
  output logic                 q_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output wavhc_pkg::out_item_t out_item_o
);
  import wavhc_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SMP  = 4'b0100,
    B_TAIL = 4'b1000
  } bstate_e;

  bstate_e     state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [14:0] scale_q;
  out_item_t   out_q, out_d;
  logic        out_valid_q;
  logic        load;
  logic        slot_free;
  logic [15:0] divisor;
  logic [15:0] trial;
  logic        ge;

  assign slot_free  = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;
  assign divisor    = (scale_q == '0) ? 16'd1 : {1'b0, scale_q};
  assign trial      = {rem_q[14:0], quo_q[15]};
  assign ge         = (trial >= divisor);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    out_d   = out_q;
    load    = 1'b0;
    q_pop_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          neg_d   = q_cmd_i.raw[15];
          quo_d   = q_cmd_i.raw[15] ? (16'd0 - q_cmd_i.raw) : q_cmd_i.raw;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = q_cmd_i.smp_valid ? B_DIV : B_TAIL;
        end
      end
      B_DIV: begin
        rem_d = ge ? (trial - divisor) : trial;
        quo_d = {quo_q[14:0], ge};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = B_SMP;
        end
      end
      B_SMP: begin
        if (slot_free) begin
          load             = 1'b1;
          out_d.kind       = KIND_SAMPLE;
          out_d.sample     = $signed(neg_q ? (16'd0 - quo_q) : quo_q);
          out_d.error_code = '0;
          out_d.last       = !cmd_q.tail_valid;
          state_d          = cmd_q.tail_valid ? B_TAIL : B_IDLE;
        end
      end
      B_TAIL: begin
        if (slot_free) begin
          load             = 1'b1;
          out_d.kind       = cmd_q.tail_kind;
          out_d.sample     = '0;
          out_d.error_code = cmd_q.tail_code;
          out_d.last       = 1'b1;
          state_d          = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      scale_q     <= SCALE_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  `WAVHC_ASSERT_NEXT(a_div_holds, (state_q == B_DIV) && (cnt_q != DIV_LAST), state_q == B_DIV, "divider left early")
  `WAVHC_ASSERT_NEXT(a_smp_beat, (state_q == B_SMP) && slot_free, out_valid_q && (out_q.kind == KIND_SAMPLE), "sample beat not loaded")
  `WAVHC_ASSERT_NEXT(a_tail_beat, (state_q == B_TAIL) && slot_free, out_valid_q && out_q.last && (out_q.kind != KIND_SAMPLE), "tail beat malformed")

endmodule
